### design/rv32_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package rv32_pkg;

    // Default memory depths in words (powers of two)
    localparam int DATA_WORDS_DEF  = 1024;
    localparam int INSTR_WORDS_DEF = 1024;

    // Request kinds carried on s_tuser
    localparam logic [1:0] OP_TICK     = 2'd0;
    localparam logic [1:0] OP_WR_INSTR = 2'd1;
    localparam logic [1:0] OP_WR_DATA  = 2'd2;
    localparam logic [1:0] OP_RD_DATA  = 2'd3;

    // Major opcodes
    localparam logic [6:0] OPC_R    = 7'h33;
    localparam logic [6:0] OPC_I    = 7'h13;
    localparam logic [6:0] OPC_LW   = 7'h03;
    localparam logic [6:0] OPC_SW   = 7'h23;
    localparam logic [6:0] OPC_BR   = 7'h63;
    localparam logic [6:0] OPC_JAL  = 7'h6F;
    localparam logic [6:0] OPC_JALR = 7'h67;

    localparam logic [6:0] F7_ALT = 7'h20;

    // Operand source codes
    localparam logic [1:0] FWD_RF  = 2'd0;
    localparam logic [1:0] FWD_MEM = 2'd1;
    localparam logic [1:0] FWD_WB  = 2'd2;

    // Branch funct3 codes
    localparam logic [2:0] BR_EQ  = 3'd0;
    localparam logic [2:0] BR_NE  = 3'd1;
    localparam logic [2:0] BR_LT  = 3'd4;
    localparam logic [2:0] BR_GE  = 3'd5;
    localparam logic [2:0] BR_LTU = 3'd6;
    localparam logic [2:0] BR_GEU = 3'd7;

    // ALU funct3 codes
    localparam logic [2:0] AF_ADD  = 3'd0;
    localparam logic [2:0] AF_SLL  = 3'd1;
    localparam logic [2:0] AF_SLT  = 3'd2;
    localparam logic [2:0] AF_SLTU = 3'd3;
    localparam logic [2:0] AF_XOR  = 3'd4;
    localparam logic [2:0] AF_SR   = 3'd5;
    localparam logic [2:0] AF_OR   = 3'd6;
    localparam logic [2:0] AF_AND  = 3'd7;

    // Fetch/decode latch
    typedef struct packed {
        logic        valid;
        logic [31:0] pc;
        logic [31:0] instr;
    } fd_t;

    // Decode/execute latch
    typedef struct packed {
        logic        valid;
        logic [31:0] pc;
        logic [31:0] imm;
        logic [31:0] val1;
        logic [31:0] val2;
        logic [6:0]  opcode;
        logic [2:0]  funct3;
        logic [6:0]  funct7;
        logic [4:0]  src1;
        logic [4:0]  src2;
        logic [4:0]  dest;
        logic        has_src1;
        logic        has_src2;
        logic        wr;
    } de_t;

    // Execute/memory latch
    typedef struct packed {
        logic        wr;
        logic [4:0]  dest;
        logic [31:0] out;
        logic [31:0] val2;
        logic        is_lw;
        logic        is_sw;
    } em_t;

    // Memory/writeback latch (load data lives in the data memory read register)
    typedef struct packed {
        logic        wr;
        logic [4:0]  dest;
        logic [31:0] out;
        logic        is_lw;
    } mw_t;

    // Per-request report, without read_data
    typedef struct packed {
        logic        stalled;
        logic [1:0]  fwd_a;
        logic [1:0]  fwd_b;
        logic        hazard_valid;
        logic [4:0]  hazard_reg;
        logic        wb_valid;
        logic [4:0]  wb_reg;
        logic [31:0] wb_value;
    } result_t;

    function automatic logic [31:0] imm_i(input logic [31:0] w);
        return {{20{w[31]}}, w[31:20]};
    endfunction

    function automatic logic [31:0] imm_s(input logic [31:0] w);
        return {{20{w[31]}}, w[31:25], w[11:7]};
    endfunction

    function automatic logic [31:0] imm_b(input logic [31:0] w);
        return {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    endfunction

    function automatic logic [31:0] imm_j(input logic [31:0] w);
        return {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
    endfunction

    function automatic logic [31:0] alu(input logic [6:0] op, input logic [2:0] f3,
                                        input logic [6:0] f7, input logic [31:0] a,
                                        input logic [31:0] b);
        logic [4:0] sh;
        sh = b[4:0];
        case (f3)
            AF_ADD:  return (op == OPC_R && f7 == F7_ALT) ? a - b : a + b;
            AF_SLL:  return a << sh;
            AF_SLT:  return {31'd0, $signed(a) < $signed(b)};
            AF_SLTU: return {31'd0, a < b};
            AF_XOR:  return a ^ b;
            AF_SR:   return (f7 == F7_ALT) ? 32'($signed(a) >>> sh) : a >> sh;
            AF_OR:   return a | b;
            default: return a & b;
        endcase
    endfunction

    function automatic logic br_taken(input logic [2:0] f3, input logic [31:0] a,
                                      input logic [31:0] b);
        case (f3)
            BR_EQ:   return a == b;
            BR_NE:   return a != b;
            BR_LT:   return $signed(a) < $signed(b);
            BR_GE:   return !($signed(a) < $signed(b));
            BR_LTU:  return a < b;
            BR_GEU:  return a >= b;
            default: return 1'b0;
        endcase
    endfunction

endpackage

`default_nettype wire

### design/rv32i_five_stage_pipeline.sv
`timescale 1ns / 1ps
`default_nettype none

// One request per cycle while s_tready is high. The report is registered and
// appears in the cycle after acceptance; a tick advances all five stages at once.
// Register file, PC and stage latches reset to zero/invalid.
// After reset a clearing pass zeroes both memories; s_tready stays low until
// both passes have finished.

module rv32i_five_stage_pipeline
    import rv32_pkg::*;
#(
    parameter int DATA_WORDS  = DATA_WORDS_DEF,
    parameter int INSTR_WORDS = INSTR_WORDS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [47:0]  s_tdata,   // address[9:0], word[41:10], zero pad
    input  wire logic [1:0]   s_tuser,   // operation[1:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // fetch_pc[31:0], stalled[32], forward_a_source[34:33], forward_b_source[36:35],
    // hazard_valid[37], hazard_reg[42:38], wb_valid[43], wb_reg[48:44],
    // wb_value[80:49], read_data[112:81], zero pad
    output logic [119:0]      m_tdata
);

    logic [31:0] rf_reg [32];
    de_t         de_reg;
    em_t         em_reg;
    mw_t         mw_reg;
    result_t     res_reg;
    logic        rd_sel_reg;
    logic        out_valid_reg;

    logic        accept;
    logic        tick;
    logic [1:0]  op;
    logic [9:0]  addr;
    logic [31:0] word;
    fd_t         fd;
    logic [31:0] pc;
    logic        if_busy;
    logic        dm_busy;
    logic [31:0] ld_data;
    logic [31:0] rd_data;
    logic [31:0] mw_out;

    assign op   = s_tuser;
    assign addr = s_tdata[9:0];
    assign word = s_tdata[41:10];

    assign s_tready = !if_busy && !dm_busy && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign tick     = accept && (op == OP_TICK);

    // Retiring value
    assign mw_out = mw_reg.is_lw ? ld_data : mw_reg.out;

    // Execute stage
    logic [31:0] a, b, res, target;
    logic [1:0]  sel_a, sel_b;
    logic        redirect;
    em_t         em_next;

    always_comb
    begin
        a        = de_reg.val1;
        b        = de_reg.val2;
        sel_a    = FWD_RF;
        sel_b    = FWD_RF;
        res      = '0;
        redirect = 1'b0;
        target   = '0;
        if (de_reg.valid && de_reg.has_src1)
        begin
            if (em_reg.wr && em_reg.dest == de_reg.src1)
            begin
                sel_a = FWD_MEM;
                a     = em_reg.out;
            end
            else if (mw_reg.wr && mw_reg.dest == de_reg.src1)
            begin
                sel_a = FWD_WB;
                a     = mw_out;
            end
        end
        if (de_reg.valid && de_reg.has_src2)
        begin
            if (em_reg.wr && em_reg.dest == de_reg.src2)
            begin
                sel_b = FWD_MEM;
                b     = em_reg.out;
            end
            else if (mw_reg.wr && mw_reg.dest == de_reg.src2)
            begin
                sel_b = FWD_WB;
                b     = mw_out;
            end
        end
        if (de_reg.valid)
        begin
            unique case (de_reg.opcode)
                OPC_R:
                    res = alu(de_reg.opcode, de_reg.funct3, de_reg.funct7, a, b);
                OPC_I:
                    res = alu(de_reg.opcode, de_reg.funct3, de_reg.funct7, a, de_reg.imm);
                OPC_LW, OPC_SW:
                    res = a + de_reg.imm;
                OPC_BR:
                begin
                    redirect = br_taken(de_reg.funct3, a, b);
                    target   = de_reg.pc + de_reg.imm;
                end
                OPC_JAL:
                begin
                    res      = de_reg.pc + 32'd4;
                    redirect = 1'b1;
                    target   = de_reg.pc + de_reg.imm;
                end
                OPC_JALR:
                begin
                    res      = de_reg.pc + 32'd4;
                    redirect = 1'b1;
                    target   = (a + de_reg.imm) & ~32'd1;
                end
                default:
                    res = '0;
            endcase
        end
        em_next.wr    = de_reg.valid && de_reg.wr;
        em_next.dest  = de_reg.dest;
        em_next.out   = res;
        em_next.val2  = (de_reg.opcode == OPC_SW) ? b : de_reg.val2;
        em_next.is_lw = de_reg.valid && de_reg.opcode == OPC_LW;
        em_next.is_sw = de_reg.valid && de_reg.opcode == OPC_SW;
    end

    // Load-use hazard against the instruction waiting in decode
    logic        fd_live;
    logic        stall;
    logic [6:0]  fd_opc;
    logic [4:0]  fd_rs1, fd_rs2;
    logic        use1, use2;

    assign fd_live = fd.valid && !redirect;
    assign fd_opc  = fd.instr[6:0];
    assign fd_rs1  = fd.instr[19:15];
    assign fd_rs2  = fd.instr[24:20];
    assign use1    = fd_opc != OPC_JAL;
    assign use2    = fd_opc == OPC_SW || fd_opc == OPC_R || fd_opc == OPC_BR;
    assign stall   = fd_live && de_reg.valid && de_reg.opcode == OPC_LW && de_reg.wr &&
                     ((use1 && de_reg.dest == fd_rs1) || (use2 && de_reg.dest == fd_rs2));

    // Decode stage, register read sees this tick's writeback
    de_t         de_dec;
    logic [31:0] w;
    logic        has_dest;

    always_comb
    begin
        w               = fd.instr;
        has_dest        = 1'b0;
        de_dec          = '0;
        de_dec.valid    = 1'b1;
        de_dec.pc       = fd.pc;
        de_dec.opcode   = w[6:0];
        de_dec.funct3   = w[14:12];
        de_dec.funct7   = w[31:25];
        de_dec.src1     = w[19:15];
        de_dec.src2     = w[24:20];
        de_dec.dest     = w[11:7];
        de_dec.has_src1 = w[6:0] != OPC_JAL;
        unique case (w[6:0])
            OPC_R:
            begin
                de_dec.has_src2 = 1'b1;
                has_dest        = 1'b1;
            end
            OPC_I, OPC_LW, OPC_JALR:
            begin
                has_dest   = 1'b1;
                de_dec.imm = imm_i(w);
            end
            OPC_SW:
            begin
                de_dec.has_src2 = 1'b1;
                de_dec.imm      = imm_s(w);
            end
            OPC_BR:
            begin
                de_dec.has_src2 = 1'b1;
                de_dec.imm      = imm_b(w);
            end
            OPC_JAL:
            begin
                has_dest   = 1'b1;
                de_dec.imm = imm_j(w);
            end
            default:
                has_dest = 1'b0;
        endcase
        de_dec.wr = has_dest && (w[11:7] != 5'd0);
        if (de_dec.has_src1)
            de_dec.val1 = (mw_reg.wr && mw_reg.dest == w[19:15]) ? mw_out : rf_reg[w[19:15]];
        if (de_dec.has_src2)
            de_dec.val2 = (mw_reg.wr && mw_reg.dest == w[24:20]) ? mw_out : rf_reg[w[24:20]];
    end

    // Per-tick report
    result_t res_tick;

    always_comb
    begin
        res_tick.stalled      = stall;
        res_tick.fwd_a        = sel_a;
        res_tick.fwd_b        = sel_b;
        res_tick.hazard_valid = stall;
        res_tick.hazard_reg   = stall ? de_reg.dest : 5'd0;
        res_tick.wb_valid     = mw_reg.wr;
        res_tick.wb_reg       = mw_reg.wr ? mw_reg.dest : 5'd0;
        res_tick.wb_value     = mw_reg.wr ? mw_out : 32'd0;
    end

    // Stage latches, register file and report register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 32; i++)
                rf_reg[i] <= '0;
            de_reg        <= '0;
            em_reg        <= '0;
            mw_reg        <= '0;
            res_reg       <= '0;
            rd_sel_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (tick)
            begin
                if (mw_reg.wr)
                    rf_reg[mw_reg.dest] <= mw_out;
                mw_reg.wr    <= em_reg.wr;
                mw_reg.dest  <= em_reg.dest;
                mw_reg.out   <= em_reg.out;
                mw_reg.is_lw <= em_reg.is_lw;
                em_reg       <= em_next;
                if (!stall && fd_live)
                    de_reg <= de_dec;
                else
                    de_reg <= '0;
            end
            if (accept)
            begin
                res_reg    <= tick ? res_tick : '0;
                rd_sel_reg <= op == OP_RD_DATA;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    rv32_fetch #(
        .INSTR_WORDS (INSTR_WORDS)
    ) u_fetch (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (accept && op == OP_WR_INSTR),
        .wr_addr  (addr),
        .wr_data  (word),
        .tick     (tick),
        .stall    (stall),
        .redirect (redirect),
        .target   (target),
        .fd       (fd),
        .pc       (pc),
        .busy     (if_busy)
    );

    rv32_dmem #(
        .DATA_WORDS (DATA_WORDS)
    ) u_dmem (
        .clk       (clk),
        .rst_n     (rst_n),
        .ld_en     (tick && em_reg.is_lw),
        .st_en     (tick && em_reg.is_sw),
        .mem_addr  (em_reg.out),
        .st_data   (em_reg.val2),
        .host_wr   (accept && op == OP_WR_DATA),
        .host_rd   (accept && op == OP_RD_DATA),
        .host_addr (addr),
        .host_data (word),
        .ld_data   (ld_data),
        .rd_data   (rd_data),
        .busy      (dm_busy)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, (rd_sel_reg ? rd_data : 32'd0), res_reg.wb_value,
                       res_reg.wb_reg, res_reg.wb_valid, res_reg.hazard_reg,
                       res_reg.hazard_valid, res_reg.fwd_b, res_reg.fwd_a,
                       res_reg.stalled, pc};

endmodule

`default_nettype wire

### design/rv32_fetch.sv
`timescale 1ns / 1ps
`default_nettype none

module rv32_fetch
    import rv32_pkg::*;
#(
    parameter int INSTR_WORDS = INSTR_WORDS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        wr_en,
    input  wire logic [9:0]  wr_addr,
    input  wire logic [31:0] wr_data,
    input  wire logic        tick,
    input  wire logic        stall,
    input  wire logic        redirect,
    input  wire logic [31:0] target,
    output fd_t              fd,
    output logic [31:0]      pc,
    output logic             busy
);

    localparam int IAW = $clog2(INSTR_WORDS);

    logic [31:0]    imem [INSTR_WORDS];
    logic [31:0]    pc_reg;
    logic [31:0]    fd_pc_reg;
    logic [31:0]    fd_instr_reg;
    logic           fd_valid_reg;
    logic [IAW:0]   clr_reg;
    logic [31:0]    pc_ex;
    logic           fetch_en;
    logic           mem_we;
    logic [IAW-1:0] mem_waddr;
    logic [31:0]    mem_wdata;

    // Redirected PC from execute, then fetch when not stalled
    assign pc_ex    = redirect ? target : pc_reg;
    assign fetch_en = tick && !stall;
    assign busy     = !clr_reg[IAW];

    // Clearing pass has priority over host writes
    always_comb
    begin
        if (busy)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg[IAW-1:0];
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = wr_en;
            mem_waddr = IAW'(wr_addr);
            mem_wdata = wr_data;
        end
    end

    // Instruction memory with registered read into the fetch latch
    always_ff @(posedge clk)
    begin
        if (mem_we)
            imem[mem_waddr] <= mem_wdata;
        if (fetch_en)
            fd_instr_reg <= imem[pc_ex[IAW+1:2]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg      <= '0;
            pc_reg       <= '0;
            fd_valid_reg <= 1'b0;
            fd_pc_reg    <= '0;
        end
        else
        begin
            if (busy)
                clr_reg <= clr_reg + 1'b1;
            if (fetch_en)
            begin
                pc_reg       <= pc_ex + 32'd4;
                fd_pc_reg    <= pc_ex;
                fd_valid_reg <= 1'b1;
            end
        end
    end

    assign fd = '{valid: fd_valid_reg, pc: fd_pc_reg, instr: fd_instr_reg};
    assign pc = pc_reg;

endmodule

`default_nettype wire

### design/rv32_dmem.sv
`timescale 1ns / 1ps
`default_nettype none

module rv32_dmem
    import rv32_pkg::*;
#(
    parameter int DATA_WORDS = DATA_WORDS_DEF
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        ld_en,
    input  wire logic        st_en,
    input  wire logic [31:0] mem_addr,
    input  wire logic [31:0] st_data,
    input  wire logic        host_wr,
    input  wire logic        host_rd,
    input  wire logic [9:0]  host_addr,
    input  wire logic [31:0] host_data,
    output logic [31:0]      ld_data,
    output logic [31:0]      rd_data,
    output logic             busy
);

    localparam int DAW = $clog2(DATA_WORDS);

    logic [31:0]    dmem [DATA_WORDS];
    logic [31:0]    ld_reg;
    logic [31:0]    rd_reg;
    logic [DAW:0]   clr_reg;
    logic           we;
    logic [DAW-1:0] waddr;
    logic [31:0]    wdata;

    assign busy = !clr_reg[DAW];

    // Write port: clearing pass, then pipeline store, then host write
    always_comb
    begin
        we    = 1'b1;
        waddr = clr_reg[DAW-1:0];
        wdata = '0;
        if (!busy)
        begin
            we = st_en || host_wr;
            if (st_en)
            begin
                waddr = mem_addr[DAW-1:0];
                wdata = st_data;
            end
            else
            begin
                waddr = DAW'(host_addr);
                wdata = host_data;
            end
        end
    end

    // Two registered read ports: load in MEM stage, host read
    always_ff @(posedge clk)
    begin
        if (we)
            dmem[waddr] <= wdata;
        if (ld_en)
            ld_reg <= dmem[mem_addr[DAW-1:0]];
        if (host_rd)
            rd_reg <= dmem[DAW'(host_addr)];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clr_reg <= '0;
        else if (busy)
            clr_reg <= clr_reg + 1'b1;
    end

    assign ld_data = ld_reg;
    assign rd_data = rd_reg;

endmodule

`default_nettype wire

### design/rv32_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module rv32_checker (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_tvalid,
    input  wire logic         s_tready,
    input  wire logic         m_tvalid,
    input  wire logic         m_tready,
    input  wire logic [119:0] m_tdata
);

    // Stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Stall flag and hazard flag agree
    a_hazard: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[32] == m_tdata[37])
        else $error("stalled and hazard_valid differ");

    // No hazard register without a stall
    a_hreg: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[32] |-> m_tdata[42:38] == 5'd0)
        else $error("hazard_reg set without stall");

    // Writeback fields are zero when nothing retires
    a_wb: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tdata[43] |-> m_tdata[48:44] == 5'd0 && m_tdata[80:49] == 32'd0)
        else $error("writeback fields set without writeback");

    // No request accepted while the output is full and not taken
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !(s_tvalid && s_tready))
        else $error("request accepted while output blocked");

endmodule

bind rv32i_five_stage_pipeline rv32_checker u_rv32_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

### test/tb_rv32i_five_stage_pipeline.sv
`timescale 1ns / 1ps

module tb_rv32i_five_stage_pipeline;
    import rv32_pkg::*;

    localparam int DWORDS = 1024;
    localparam int IWORDS = 1024;
    localparam int IDLE_LIMIT = 5000;

    // One expected report from the core
    typedef struct {
        logic [31:0] pc;
        logic        stalled;
        logic [1:0]  fwd_a;
        logic [1:0]  fwd_b;
        logic        hz_valid;
        logic [4:0]  hz_reg;
        logic        wb_valid;
        logic [4:0]  wb_reg;
        logic [31:0] wb_value;
        logic [31:0] rd_data;
    } report_t;

    // Decoded stage contents
    typedef struct {
        logic        valid;
        logic [31:0] pc, imm, val1, val2, out;
        logic [6:0]  opcode, funct7;
        logic [2:0]  funct3;
        logic [4:0]  src1, src2, dest;
        logic        has1, has2, hasd;
    } stage_t;

    int errors = 0;

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch on %s: got %h, expected %h at %0t", field, got, want, $realtime);
    endtask

    // Pipeline predictor and the queue of expected reports
    class core_scoreboard;
        logic [31:0] regs [32];
        logic [31:0] dmem [DWORDS];
        logic [31:0] imem [IWORDS];
        logic [31:0] pc;
        logic        fd_valid;
        logic [31:0] fd_pc, fd_instr;
        stage_t      de, em, mw;
        report_t     pending[$];
        int          ticks, stalls, writebacks, taken;

        function void clear();
            foreach (regs[i]) regs[i] = '0;
            foreach (dmem[i]) dmem[i] = '0;
            foreach (imem[i]) imem[i] = '0;
            pc = '0;
            fd_valid = 1'b0; fd_pc = '0; fd_instr = '0;
            de = '{default: '0}; em = '{default: '0}; mw = '{default: '0};
        endfunction

        function logic [31:0] sx(input logic [31:0] v, input int bits);
            logic [31:0] m;
            m = 32'd1 << (bits - 1);
            v = v & ((m << 1) - 1);
            return (v ^ m) - m;
        endfunction

        function logic writes(input stage_t s);
            return s.valid && s.hasd && s.dest != 0;
        endfunction

        function logic lt_s(input logic [31:0] a, input logic [31:0] b);
            return (a ^ 32'h8000_0000) < (b ^ 32'h8000_0000);
        endfunction

        function logic [31:0] compute(input stage_t s, input logic [31:0] a,
                                      input logic [31:0] b);
            logic [4:0] sh;
            sh = b[4:0];
            case (s.funct3)
                AF_ADD:  return (s.opcode == OPC_R && s.funct7 == F7_ALT) ? a - b : a + b;
                AF_SLL:  return a << sh;
                AF_SLT:  return {31'd0, lt_s(a, b)};
                AF_SLTU: return {31'd0, a < b};
                AF_XOR:  return a ^ b;
                AF_SR:
                    if (s.funct7 == F7_ALT && a[31]) return (a >> sh) | ~(32'hFFFF_FFFF >> sh);
                    else return a >> sh;
                AF_OR:   return a | b;
                default: return a & b;
            endcase
        endfunction

        function logic cond_met(input logic [2:0] f3, input logic [31:0] a,
                                input logic [31:0] b);
            case (f3)
                BR_EQ:   return a == b;
                BR_NE:   return a != b;
                BR_LT:   return lt_s(a, b);
                BR_GE:   return !lt_s(a, b);
                BR_LTU:  return a < b;
                BR_GEU:  return a >= b;
                default: return 1'b0;
            endcase
        endfunction

        function logic [31:0] operand(input logic [4:0] src, input logic has,
                                      input logic [31:0] rv, input stage_t retiring,
                                      output logic [1:0] sel);
            sel = FWD_RF;
            if (!has) return rv;
            if (writes(mw) && mw.dest == src) begin sel = FWD_MEM; return mw.out; end
            if (writes(retiring) && retiring.dest == src) begin sel = FWD_WB; return retiring.out; end
            return rv;
        endfunction

        function void decode_into(input logic [31:0] dpc, input logic [31:0] w);
            de = '{default: '0};
            de.valid = 1'b1; de.pc = dpc;
            de.opcode = w[6:0]; de.funct3 = w[14:12]; de.funct7 = w[31:25];
            de.src1 = w[19:15]; de.src2 = w[24:20]; de.dest = w[11:7];
            de.has1 = de.opcode != OPC_JAL;
            case (de.opcode)
                OPC_R: begin de.has2 = 1; de.hasd = 1; end
                OPC_I, OPC_LW, OPC_JALR: begin de.hasd = 1; de.imm = sx(w >> 20, 12); end
                OPC_SW: begin de.has2 = 1; de.imm = sx({w[31:25], w[11:7]}, 12); end
                OPC_BR: begin
                    de.has2 = 1;
                    de.imm = sx({w[31], w[7], w[30:25], w[11:8], 1'b0}, 13);
                end
                OPC_JAL: begin
                    de.hasd = 1;
                    de.imm = sx({w[31], w[19:12], w[20], w[30:21], 1'b0}, 21);
                end
                default: ;
            endcase
            de.val1 = de.has1 ? regs[de.src1] : '0;
            de.val2 = de.has2 ? regs[de.src2] : '0;
        endfunction

        function void clock_tick(inout report_t r);
            stage_t retiring;
            logic [31:0] a, b, res, w;
            logic u1, u2, stall;
            retiring = mw;
            stall = 0;
            ticks++;
            if (writes(retiring)) begin
                regs[retiring.dest] = retiring.out;
                r.wb_valid = 1; r.wb_reg = retiring.dest; r.wb_value = retiring.out;
                writebacks++;
            end
            // memory stage
            mw = em;
            if (em.valid) begin
                if (em.opcode == OPC_LW) mw.out = dmem[em.out % DWORDS];
                else if (em.opcode == OPC_SW) dmem[em.out % DWORDS] = em.val2;
            end
            // execute stage
            em = de;
            if (de.valid) begin
                a = operand(de.src1, de.has1, de.val1, retiring, r.fwd_a);
                b = operand(de.src2, de.has2, de.val2, retiring, r.fwd_b);
                res = '0;
                if (de.opcode == OPC_R) res = compute(de, a, b);
                else if (de.opcode == OPC_I) res = compute(de, a, de.imm);
                else if (de.opcode == OPC_LW || de.opcode == OPC_SW) res = a + de.imm;
                else if (de.opcode == OPC_BR) begin
                    if (cond_met(de.funct3, a, b)) begin
                        pc = de.pc + de.imm;
                        fd_valid = 0; fd_pc = '0; fd_instr = '0;
                        taken++;
                    end
                end else if (de.opcode == OPC_JAL || de.opcode == OPC_JALR) begin
                    res = de.pc + 4;
                    pc = (de.opcode == OPC_JAL) ? de.pc + de.imm : (a + de.imm) & ~32'd1;
                    fd_valid = 0; fd_pc = '0; fd_instr = '0;
                    taken++;
                end
                em.out = res;
                if (de.opcode == OPC_SW) em.val2 = b;
            end
            // load-use check
            if (fd_valid && de.valid && de.opcode == OPC_LW && de.hasd && de.dest != 0) begin
                w = fd_instr;
                u1 = w[6:0] != OPC_JAL;
                u2 = w[6:0] == OPC_SW || w[6:0] == OPC_R || w[6:0] == OPC_BR;
                if ((u1 && de.dest == w[19:15]) || (u2 && de.dest == w[24:20])) begin
                    stall = 1; r.hz_reg = de.dest;
                end
            end
            if (!stall && fd_valid) decode_into(fd_pc, fd_instr);
            else de = '{default: '0};
            if (!stall) begin
                fd_instr = imem[(pc >> 2) % IWORDS];
                fd_pc = pc; fd_valid = 1;
                pc = pc + 4;
            end
            r.stalled = stall; r.hz_valid = stall;
            if (stall) stalls++;
        endfunction

        function void note_request(input logic [1:0] op, input logic [9:0] addr,
                                   input logic [31:0] word);
            report_t r;
            r = '{default: '0};
            case (op)
                OP_TICK:     clock_tick(r);
                OP_WR_INSTR: imem[addr % IWORDS] = word;
                OP_WR_DATA:  dmem[addr % DWORDS] = word;
                default:     r.rd_data = dmem[addr % DWORDS];
            endcase
            r.pc = pc;
            pending.push_back(r);
        endfunction

        task check_report(input logic [119:0] d);
            report_t e;
            if (pending.size() == 0) begin
                report_mismatch("unexpected report", d[31:0], '0);
                return;
            end
            e = pending.pop_front();
            if (d[31:0] !== e.pc) report_mismatch("fetch_pc", d[31:0], e.pc);
            if (d[32] !== e.stalled) report_mismatch("stalled", d[32], e.stalled);
            if (d[34:33] !== e.fwd_a) report_mismatch("forward_a", d[34:33], e.fwd_a);
            if (d[36:35] !== e.fwd_b) report_mismatch("forward_b", d[36:35], e.fwd_b);
            if (d[37] !== e.hz_valid) report_mismatch("hazard_valid", d[37], e.hz_valid);
            if (d[42:38] !== e.hz_reg) report_mismatch("hazard_reg", d[42:38], e.hz_reg);
            if (d[43] !== e.wb_valid) report_mismatch("wb_valid", d[43], e.wb_valid);
            if (d[48:44] !== e.wb_reg) report_mismatch("wb_reg", d[48:44], e.wb_reg);
            if (d[80:49] !== e.wb_value) report_mismatch("wb_value", d[80:49], e.wb_value);
            if (d[112:81] !== e.rd_data) report_mismatch("read_data", d[112:81], e.rd_data);
            if (d[119:113] !== '0) report_mismatch("pad", d[119:113], '0);
        endtask
    endclass

    logic         clk = 0;
    logic         rst_n = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;
    logic [1:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [119:0] m_tdata;

    core_scoreboard sb = new();
    int  idle_cycles = 0;
    bit  stall_on = 1;
    int  sent = 0;
    int  gap_left = 0;

    rv32i_five_stage_pipeline dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always
    begin
        #2 clk = 1;
        #2 clk = 0;
    end

    // Receiver: stall pattern and report checking
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_report(m_tdata);
        if (rst_n && ((s_tvalid && s_tready) || (m_tvalid && m_tready))) idle_cycles <= 0;
        else if (rst_n) idle_cycles <= idle_cycles + 1;
        if (stall_on) m_tready <= ($urandom_range(0, 3) != 0);
        else m_tready <= 1'b1;
    end

    // Stall phases toggle now and then, leaving stretches of full rate
    always @(posedge clk)
        if ($urandom_range(0, 199) == 0) stall_on <= ~stall_on;

    // Watchdog on the handshakes
    always @(posedge clk)
    begin
        if (idle_cycles > IDLE_LIMIT + DWORDS) begin
            $display("watchdog: no progress, %0d reports outstanding", sb.pending.size());
            $display("** rv32i_five_stage_pipeline: FAILED **");
            $finish;
        end
    end

    // Drive one request and hold it until accepted, with bursty gaps
    task automatic send(input logic [1:0] op, input logic [9:0] addr, input logic [31:0] word);
        if (gap_left > 0)
            s_tvalid <= 1'b0;
        while (gap_left > 0) begin
            @(posedge clk);
            gap_left--;
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {6'd0, word, addr};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.note_request(op, addr, word);
        sent++;
        if ($urandom_range(0, 7) == 0)
            gap_left = $urandom_range(1, 6);
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        go_idle();
        while (sb.pending.size() != 0) @(posedge clk);
    endtask

    function automatic logic [31:0] r_type(input logic [6:0] f7, input logic [4:0] rs2,
                                           input logic [4:0] rs1, input logic [2:0] f3,
                                           input logic [4:0] rd, input logic [6:0] opc);
        return {f7, rs2, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] i_type(input logic [11:0] imm, input logic [4:0] rs1,
                                           input logic [2:0] f3, input logic [4:0] rd,
                                           input logic [6:0] opc);
        return {imm, rs1, f3, rd, opc};
    endfunction

    function automatic logic [31:0] s_type(input logic [11:0] imm, input logic [4:0] rs2,
                                           input logic [4:0] rs1);
        return {imm[11:5], rs2, rs1, 3'd2, imm[4:0], OPC_SW};
    endfunction

    function automatic logic [31:0] b_type(input logic [12:0] imm, input logic [4:0] rs2,
                                           input logic [4:0] rs1, input logic [2:0] f3);
        return {imm[12], imm[10:5], rs2, rs1, f3, imm[4:1], imm[11], OPC_BR};
    endfunction

    // Random instruction biased to small register numbers so hazards happen often
    function automatic logic [31:0] rand_instr();
        logic [4:0] rd, rs1, rs2;
        logic [2:0] f3;
        logic [31:0] w;
        rd = $urandom_range(0, 5); rs1 = $urandom_range(0, 5); rs2 = $urandom_range(0, 5);
        f3 = $urandom_range(0, 7);
        w = $urandom;
        case ($urandom_range(0, 11))
            0, 1, 2: return r_type($urandom_range(0, 1) ? F7_ALT : 7'd0, rs2, rs1, f3, rd, OPC_R);
            3, 4, 5: return i_type(w[11:0] & (f3 == AF_SR ? 12'h41F : 12'hFFF), rs1, f3, rd, OPC_I);
            6, 7:    return i_type(w[11:0] & 12'h03F, rs1, 3'd2, rd, OPC_LW);
            8:       return s_type(w[11:0] & 12'h03F, rs2, rs1);
            9:       return b_type({w[12] & w[13], w[11:4] & 8'h07, w[3:1], 1'b0}, rs2, rs1, f3);
            10:      return $urandom_range(0, 1)
                            ? {w[31], w[30:12] & 19'h0007F, w[11:7], OPC_JAL} & 32'h80FFFFFF
                            : i_type(w[11:0] & 12'h0FC, rs1, 3'd0, rd, OPC_JALR);
            default: return w;
        endcase
    endfunction

    initial
    begin
        logic [1:0]  op;
        logic [31:0] w;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed program: ALU ops, forwarding, load-use, store, branches, jumps
        send(OP_WR_DATA, 10'd0, 32'hFFFF_FFFF);
        send(OP_WR_DATA, 10'd1023, 32'h8000_0000);
        send(OP_RD_DATA, 10'd1023, '0);
        send(OP_WR_INSTR, 10'd0, i_type(12'h7FF, 5'd0, AF_ADD, 5'd1, OPC_I));
        send(OP_WR_INSTR, 10'd1, i_type(12'h800, 5'd0, AF_ADD, 5'd2, OPC_I));
        send(OP_WR_INSTR, 10'd2, r_type(F7_ALT, 5'd2, 5'd1, AF_ADD, 5'd3, OPC_R));
        send(OP_WR_INSTR, 10'd3, i_type(12'h3FF, 5'd0, 3'd2, 5'd4, OPC_LW));
        send(OP_WR_INSTR, 10'd4, r_type(F7_ALT, 5'd4, 5'd2, AF_SR, 5'd5, OPC_R));
        send(OP_WR_INSTR, 10'd5, s_type(12'd5, 5'd5, 5'd0));
        send(OP_WR_INSTR, 10'd6, b_type(13'd8, 5'd1, 5'd1, BR_EQ));
        send(OP_WR_INSTR, 10'd7, 32'hFFFF_FFFF);
        send(OP_WR_INSTR, 10'd8, b_type(13'd8, 5'd1, 5'd2, 3'd2));
        send(OP_WR_INSTR, 10'd9, {1'b0, 10'd2, 1'b0, 8'd0, 5'd6, OPC_JAL});
        send(OP_WR_INSTR, 10'd11, i_type(12'h0, 5'd6, 3'd0, 5'd7, OPC_JALR));
        for (int i = 0; i < 12; i++) send(OP_TICK, '0, '0);
        send(OP_RD_DATA, 10'd5, '0);
        drain();

        // Random programs: load code, run it, peek at data
        while (sent < 620) begin
            op = ($urandom_range(0, 9) < 6) ? OP_TICK : 2'($urandom_range(1, 3));
            w = (op == OP_WR_INSTR) ? rand_instr() : $urandom;
            if (op == OP_WR_INSTR && $urandom_range(0, 3) != 0)
                send(op, 10'($urandom_range(0, 31)), w);
            else
                send(op, (op == OP_TICK && $urandom_range(0, 1)) ? '0 : 10'($urandom), w);
            if (sent == 350) drain();
        end

        drain();
        repeat (10) @(posedge clk);
        $display("covered %0d requests, %0d ticks, %0d stalls, %0d writebacks, %0d redirects",
                 sent, sb.ticks, sb.stalls, sb.writebacks, sb.taken);
        if (errors == 0 && sb.pending.size() == 0)
            $display("** rv32i_five_stage_pipeline: PASSED **");
        else
            $display("** rv32i_five_stage_pipeline: FAILED **");
        $finish;
    end

endmodule
